### sv/chd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the content hash deduplicating cache.
package chd_pkg;

  // FNV-1a 64-bit offset basis. The prime 0x100000001B3 is applied as shifts and adds.
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_STORE  = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_INVALID   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_B,
    S_MUL_C,
    S_MUL_D,
    S_DECIDE,
    S_SEARCH,
    S_RESULT
  } state_e;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] handle;
    logic [7:0]  stage;
    logic [2:0]  language;
  } entry_t;

  // What a finished request does when its result is delivered.
  typedef struct packed {
    status_e status;
    logic    write_entry;
    logic    bump_handle;
    logic    count_hit;
    logic    count_miss;
  } verdict_t;

  typedef struct packed {
    logic     load;
    logic     mul_b;
    logic     mul_c;
    logic     mul_d;
    logic     search_start;
    logic     search_run;
    logic     emit;
    verdict_t verdict;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    last;
    logic    hash_zero;
    logic    full;
    logic    search_done;
    logic    search_hit;
    logic    out_busy;
  } stat_t;

endpackage

### sv/chd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the content hash deduplicating cache.
module chd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  chd_pkg::action_e action_i,
  input  chd_pkg::stat_t   stat_i,
  output logic             in_stall_o,
  output chd_pkg::cmd_t    cmd_o
);
  import chd_pkg::*;

  state_e   state_q, state_d;
  verdict_t verdict_q, verdict_d;

  // A new entry is written unless the table is full.
  function automatic verdict_t insert_verdict(logic full, logic bump, logic miss);
    verdict_t v;
    v             = '0;
    v.count_miss  = miss;
    if (full) begin
      v.status = ST_FULL;
    end else begin
      v.status      = ST_INSERTED;
      v.write_entry = 1'b1;
      v.bump_handle = bump;
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      verdict_q <= '0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    verdict_d      = verdict_q;
    cmd_o          = '0;
    cmd_o.verdict  = verdict_q;
    in_stall_o     = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (action_i)
            ACT_BYTE:              state_d = S_MUL_B;
            ACT_LOOKUP, ACT_STORE: state_d = S_DECIDE;
            default:               state_d = S_IDLE;
          endcase
        end
      end
      S_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_MUL_C;
      end
      S_MUL_C: begin
        cmd_o.mul_c = 1'b1;
        state_d     = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul_d = 1'b1;
        state_d     = stat_i.last ? S_DECIDE : S_IDLE;
      end
      S_DECIDE: begin
        case (stat_i.action)
          ACT_BYTE: begin
            if (stat_i.hash_zero) begin
              verdict_d = insert_verdict(stat_i.full, 1'b1, 1'b0);
              state_d   = S_RESULT;
            end else begin
              cmd_o.search_start = 1'b1;
              state_d            = S_SEARCH;
            end
          end
          ACT_LOOKUP: begin
            if (stat_i.hash_zero) begin
              verdict_d        = '0;
              verdict_d.status = ST_INVALID;
              state_d          = S_RESULT;
            end else begin
              cmd_o.search_start = 1'b1;
              state_d            = S_SEARCH;
            end
          end
          ACT_STORE: begin
            verdict_d = insert_verdict(stat_i.full, 1'b0, 1'b0);
            state_d   = S_RESULT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEARCH: begin
        cmd_o.search_run = 1'b1;
        if (stat_i.search_done) begin
          state_d = S_RESULT;
          if (stat_i.search_hit) begin
            verdict_d           = '0;
            verdict_d.status    = ST_HIT;
            verdict_d.count_hit = 1'b1;
          end else if (stat_i.action == ACT_BYTE) begin
            verdict_d = insert_verdict(stat_i.full, 1'b1, 1'b1);
          end else begin
            verdict_d            = '0;
            verdict_d.status     = ST_NOT_FOUND;
            verdict_d.count_miss = 1'b1;
          end
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### sv/chd_datapath.sv
`timescale 1ns / 1ps
// Hash unit, slot memory, search logic, counters and result register of the cache.
module chd_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chd_pkg::cmd_t    cmd_i,
  output chd_pkg::stat_t   stat_o,
  input  chd_pkg::action_e action_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [7:0]       stage_i,
  input  logic [2:0]       language_i,
  input  logic [63:0]      key_hash_i,
  input  logic [31:0]      entry_handle_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic [5:0]       slot_o,
  output logic [31:0]      handle_o,
  output logic [7:0]       entry_stage_o,
  output logic [2:0]       entry_language_o,
  output logic [63:0]      hash_value_o,
  output logic [31:0]      hit_count_o,
  output logic [31:0]      miss_count_o,
  output logic [6:0]       entry_count_o
);
  import chd_pkg::*;

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(TABLE_ENTRIES);

  logic [63:0] acc_q, x_q, t_q, u_q, hash_q;
  logic [63:0] x_in, t_in, h_final;
  action_e     action_q;
  logic        last_q;
  logic [7:0]  stage_q;
  logic [2:0]  lang_q;
  logic [31:0] req_handle_q;

  logic [FillW-1:0] fill_q, fill_d, srch_addr_q;
  logic             rd_pend_q, issue, match;
  logic [IdxW-1:0]  rd_idx_q, hit_slot_q;
  entry_t           rd_word_q, hit_word_q, new_entry;
  entry_t           slot_mem_q [TABLE_ENTRIES];

  logic [31:0] next_handle_q, hits_q, misses_q, hits_d, misses_d, handle_sel;
  logic        out_valid_q, out_busy;
  logic [2:0]  out_status_q;
  logic [5:0]  out_slot_q;
  logic [31:0] out_handle_q, out_hits_q, out_misses_q;
  logic [7:0]  out_stage_q;
  logic [2:0]  out_lang_q;
  logic [63:0] out_hash_q;
  logic [6:0]  out_count_q;

  // prime * x = (x << 40) + 3x * (1 + 16 + 128), spread over the multiply steps.
  assign x_in    = acc_q ^ {56'd0, data_byte_i};
  assign t_in    = x_in + (x_in << 1);
  assign h_final = u_q + {x_q[23:0], 40'd0};

  assign issue = cmd_i.search_run && (srch_addr_q < fill_q);
  assign match = rd_pend_q && (rd_word_q.hash == hash_q);

  assign handle_sel = (action_q == ACT_STORE) ? req_handle_q : next_handle_q;
  assign new_entry  = '{hash: hash_q, handle: handle_sel, stage: stage_q, language: lang_q};
  assign hits_d     = hits_q + 32'(cmd_i.verdict.count_hit);
  assign misses_d   = misses_q + 32'(cmd_i.verdict.count_miss);
  assign fill_d     = fill_q + FillW'(cmd_i.verdict.write_entry);
  assign out_busy   = out_valid_q && out_stall_i;

  always_comb begin
    stat_o.action      = action_q;
    stat_o.last        = last_q;
    stat_o.hash_zero   = (hash_q == 64'd0);
    stat_o.full        = (fill_q == FillMax);
    stat_o.search_done = match || (!rd_pend_q && !issue);
    stat_o.search_hit  = match;
    stat_o.out_busy    = out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= FNV_BASIS;
      action_q      <= ACT_IGNORE;
      last_q        <= 1'b0;
      fill_q        <= '0;
      srch_addr_q   <= '0;
      rd_pend_q     <= 1'b0;
      next_handle_q <= 32'd1;
      hits_q        <= '0;
      misses_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        action_q <= action_i;
        last_q   <= last_byte_i;
      end
      if (cmd_i.mul_d) begin
        acc_q <= last_q ? FNV_BASIS : h_final;
      end
      if (cmd_i.search_start) begin
        srch_addr_q <= '0;
        rd_pend_q   <= 1'b0;
      end else if (cmd_i.search_run) begin
        rd_pend_q <= issue;
        if (issue) begin
          srch_addr_q <= srch_addr_q + FillW'(1);
        end
      end
      if (cmd_i.emit) begin
        fill_q   <= fill_d;
        hits_q   <= hits_d;
        misses_q <= misses_d;
        if (cmd_i.verdict.bump_handle) begin
          next_handle_q <= next_handle_q + 32'd1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stage_q      <= stage_i;
      lang_q       <= language_i;
      req_handle_q <= entry_handle_i;
      if (action_i == ACT_BYTE) begin
        x_q <= x_in;
        t_q <= t_in;
      end else begin
        hash_q <= key_hash_i;
      end
    end
    if (cmd_i.mul_b) begin
      u_q <= t_q + (t_q << 4);
    end
    if (cmd_i.mul_c) begin
      u_q <= u_q + (t_q << 7);
    end
    if (cmd_i.mul_d && last_q) begin
      hash_q <= h_final;
    end
    if (issue) begin
      rd_idx_q <= srch_addr_q[IdxW-1:0];
    end
    if (cmd_i.search_run && match) begin
      hit_slot_q <= rd_idx_q;
      hit_word_q <= rd_word_q;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.verdict.status;
      out_hash_q   <= hash_q;
      out_hits_q   <= hits_d;
      out_misses_q <= misses_d;
      out_count_q  <= 7'(fill_d);
      case (cmd_i.verdict.status)
        ST_HIT: begin
          out_slot_q   <= 6'(hit_slot_q);
          out_handle_q <= hit_word_q.handle;
          out_stage_q  <= hit_word_q.stage;
          out_lang_q   <= hit_word_q.language;
        end
        ST_INSERTED: begin
          out_slot_q   <= 6'(fill_q);
          out_handle_q <= handle_sel;
          out_stage_q  <= stage_q;
          out_lang_q   <= lang_q;
        end
        default: begin
          out_slot_q   <= '0;
          out_handle_q <= '0;
          out_stage_q  <= '0;
          out_lang_q   <= '0;
        end
      endcase
    end
  end

  // Slot memory: one write port for inserts, one registered read port for the search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && cmd_i.verdict.write_entry) begin
      slot_mem_q[fill_q[IdxW-1:0]] <= new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_word_q <= slot_mem_q[srch_addr_q[IdxW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign slot_o           = out_slot_q;
  assign handle_o         = out_handle_q;
  assign entry_stage_o    = out_stage_q;
  assign entry_language_o = out_lang_q;
  assign hash_value_o     = out_hash_q;
  assign hit_count_o      = out_hits_q;
  assign miss_count_o     = out_misses_q;
  assign entry_count_o    = out_count_q;

endmodule

### sv/content_hash_dedup_cache.sv
`timescale 1ns / 1ps
// Top level of the content hash deduplicating cache: controller, datapath and checks.
//
// The block folds program bytes into a 64-bit FNV-1a hash and, on the byte marked last,
// looks the hash up in a table of TABLE_ENTRIES slots; a miss claims the lowest free slot
// with a fresh handle. Two further requests look up a given hash or store a given entry.
// Slots are only ever filled in ascending order and never freed, so the occupied slots are
// always the lowest ones and a fill count stands in for per-slot valid bits; the slot memory
// needs no clearing pass after reset. A program byte that is not last runs, after the request
// is taken, through the three shift-and-add steps of the multiply by the FNV prime before
// the next request is taken. The search reads the slot memory through its single registered
// read port, one slot a cycle, and ends at the first hit or after the last occupied slot. A
// lookup of hash zero, a closing byte whose hash is zero and a store skip the search. A
// result is held in an output register, so the next request is taken while an earlier
// result waits; a result waits in the controller only when the output register is still
// stalled.
module content_hash_dedup_cache #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  stage_i,
  input  logic [2:0]  language_i,
  input  logic [63:0] key_hash_i,
  input  logic [31:0] entry_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] handle_o,
  output logic [7:0]  entry_stage_o,
  output logic [2:0]  entry_language_o,
  output logic [63:0] hash_value_o,
  output logic [31:0] hit_count_o,
  output logic [31:0] miss_count_o,
  output logic [6:0]  entry_count_o
);
  import chd_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  action_e action_in;

  assign action_in = action_e'(action_i);

  chd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_in),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  chd_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_in),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .stage_i          (stage_i),
    .language_i       (language_i),
    .key_hash_i       (key_hash_i),
    .entry_handle_i   (entry_handle_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .handle_o         (handle_o),
    .entry_stage_o    (entry_stage_o),
    .entry_language_o (entry_language_o),
    .hash_value_o     (hash_value_o),
    .hit_count_o      (hit_count_o),
    .miss_count_o     (miss_count_o),
    .entry_count_o    (entry_count_o)
  );

  // A result is only written into the output register when that register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !stat.out_busy)
    else $error("result written over a stalled output");

  // A slot is never claimed in a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.verdict.write_entry) |-> !stat.full)
    else $error("entry written into a full table");

  // A store request never runs a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.search_run |-> (stat.action == ACT_BYTE || stat.action == ACT_LOOKUP))
    else $error("search started for a request that has none");

  // The request port opens again only after a result has been handed on or none was due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.search_run && stat.search_done) |=> in_stall_o)
    else $error("request taken before the search result was delivered");

endmodule
